>>> design/assert_macros.svh
// Assertion macros shared by the packed bit-field store RTL.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PBFS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packed bit-field store assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PBFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packed bit-field store assertion failed");

`endif

>>> design/pbfs_pkg.sv
// Package for the packed bit-field store: field widths, operation, status and
// register codes, the memory control struct and the low mask helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbfs_pkg;

   localparam int unsigned WORD_BITS           = 64;
   localparam int unsigned OFF_BITS            = 6;
   localparam int unsigned STORE_WORDS_DEFAULT = 1024;

   localparam int unsigned OP_BITS     = 3;
   localparam int unsigned POS_BITS    = 16;
   localparam int unsigned FW_BITS     = 7;
   localparam int unsigned SIZE_BITS   = 17;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned BP_BITS     = 23;
   localparam int unsigned CSR_IDX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS = 17;

   localparam logic [OP_BITS-1:0] OP_SET       = 3'd0;
   localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_TEST      = 3'd2;
   localparam logic [OP_BITS-1:0] OP_READ      = 3'd3;
   localparam logic [OP_BITS-1:0] OP_WRITE     = 3'd4;
   localparam logic [OP_BITS-1:0] OP_READ_REC  = 3'd5;
   localparam logic [OP_BITS-1:0] OP_WRITE_REC = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_VECTOR_BITS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECORD_WIDTH = 2'd1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // Mask of the w low bits, all ones for w of 64 or more.
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [FW_BITS-1:0] w);
      logic [WORD_BITS-1:0] m;
      if (w >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << w[OFF_BITS-1:0]) - 64'd1;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> design/pbfs_store.sv
// Word memory of the packed bit-field store: one write port and one read port,
// read data registered. Depends on pbfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbfs_store #(
   parameter int unsigned WORDS     = pbfs_pkg::STORE_WORDS_DEFAULT,
   parameter int unsigned ADDR_BITS = 10
) (
   input  logic                           clock,
   input  pbfs_pkg::mem_ctl_type          ctl,
   input  logic [ADDR_BITS-1:0]           wr_addr,
   input  logic [pbfs_pkg::WORD_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   output logic [pbfs_pkg::WORD_BITS-1:0] rd_data
);
   import pbfs_pkg::*;

   logic [WORD_BITS-1:0] mem_ff [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/packed_bit_field_store.sv
// Packed bit-field store: one transaction at a time, passed after acceptance through
// S_CHECK, S_RD0, S_RD1 and S_RESP to the output register; the next is taken only in
// S_IDLE, after the read-modify-write sequence over the single write port of the word
// memory (two words for a straddling field). Reset is synchronous: the memory is then
// cleared one word a cycle, all STORE_WORDS words (1024 by default), while req_stall
// stays high; csr writes are taken. After reset vector_bits is 65536, record_width 0.
`timescale 1ns / 1ps
`default_nettype none

module packed_bit_field_store #(
   parameter int unsigned STORE_WORDS = pbfs_pkg::STORE_WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pbfs_pkg::OP_BITS-1:0]       req_operation,
   input  logic [pbfs_pkg::POS_BITS-1:0]      req_position,
   input  logic [pbfs_pkg::FW_BITS-1:0]       req_field_width,
   input  logic [pbfs_pkg::WORD_BITS-1:0]     req_write_value,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pbfs_pkg::WORD_BITS-1:0]     rsp_read_value,
   output logic [pbfs_pkg::SIZE_BITS-1:0]     rsp_next_position,
   output logic [pbfs_pkg::STATUS_BITS-1:0]   rsp_status,
   // Configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pbfs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pbfs_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import pbfs_pkg::*;

   `include "assert_macros.svh"

   // Word address width and the capacity of the memory in bits.
   localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam logic [BP_BITS-1:0] CAP_BITS  = BP_BITS'(STORE_WORDS * WORD_BITS);
   localparam logic [AW-1:0]      LAST_WORD = AW'(STORE_WORDS - 1);

   // The sequencer: a transaction is taken in S_IDLE, checked in S_CHECK (first word
   // read issued), modified in S_RD0 (first word written, second word read) and
   // S_RD1 (second word written, read field assembled), then handed to the output
   // register in S_RESP.
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_CHECK = 6'b000100,
      S_RD0   = 6'b001000,
      S_RD1   = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   // Outcome of the range and width checks for the transaction in flight.
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   do_read;
      logic                   do_write;
      logic                   span;
      logic [OFF_BITS-1:0]    off;
      logic [FW_BITS-1:0]     mw;
      logic [AW-1:0]          blk;
      logic [SIZE_BITS-1:0]   next;
   } chk_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_addr_ff;
   logic [SIZE_BITS-1:0]    vector_bits_ff;
   logic [FW_BITS-1:0]      record_width_ff;

   logic [OP_BITS-1:0]      op_ff;
   logic [POS_BITS-1:0]     pos_ff;
   logic [FW_BITS-1:0]      fw_ff;
   logic [WORD_BITS-1:0]    val_ff;
   logic [BP_BITS-1:0]      bp_ff;
   chk_type                 chk_ff, chk_in;
   logic [WORD_BITS-1:0]    w0_ff;
   logic [WORD_BITS-1:0]    res_value_ff;

   logic                    rsp_valid_ff;
   logic [WORD_BITS-1:0]    rsp_read_value_ff;
   logic [SIZE_BITS-1:0]    rsp_next_position_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff;

   logic                    req_take;
   logic                    rsp_free;
   logic [BP_BITS-1:0]      rec_bp;

   logic [SIZE_BITS-1:0]    size;
   logic                    is_rec;
   logic [FW_BITS-1:0]      width;
   logic [BP_BITS:0]        end_bp;
   logic [SIZE_BITS-1:0]    room;
   logic [FW_BITS-1:0]      mw_rd;
   logic                    past_size;
   logic                    value_fits;

   logic [WORD_BITS-1:0]    wval;
   logic [2*WORD_BITS-1:0]  fmask;
   logic [2*WORD_BITS-1:0]  fdata;
   logic [2*WORD_BITS-1:0]  pair;

   mem_ctl_type             mem_ctl;
   logic [AW-1:0]           mem_wr_addr;
   logic [WORD_BITS-1:0]    mem_wr_data;
   logic [AW-1:0]           mem_rd_addr;
   logic [WORD_BITS-1:0]    mem_rd_data;

   // Handshakes. Requests are only taken in S_IDLE; the output register lets a new
   // transaction in while the previous response still waits to be taken.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Record position: index times record width, registered straight away.
   assign rec_bp = req_position * record_width_ff;

   // Configuration registers. Writes are expected only while the block is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_bits_ff  <= 17'h10000;
         record_width_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VECTOR_BITS:  vector_bits_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_RECORD_WIDTH: record_width_ff <= csr_data[FW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Usable size in bits: the smaller of vector_bits and the memory capacity.
   assign size = ({6'b0, vector_bits_ff} < CAP_BITS) ? vector_bits_ff
                                                    : CAP_BITS[SIZE_BITS-1:0];

   assign is_rec     = (op_ff == OP_READ_REC) || (op_ff == OP_WRITE_REC);
   assign width      = (op_ff == OP_SET || op_ff == OP_CLEAR || op_ff == OP_TEST) ? 7'd1
                     : (is_rec ? record_width_ff : fw_ff);
   assign end_bp     = (BP_BITS+1)'(bp_ff) + (BP_BITS+1)'(width);
   assign past_size  = ({6'b0, size} <= bp_ff);
   // Bits left from the start to the end of the vector, meaningful only in range.
   assign room       = size - bp_ff[SIZE_BITS-1:0];
   assign mw_rd      = (room < SIZE_BITS'(width)) ? room[FW_BITS-1:0] : width;
   assign value_fits = ((val_ff & ~low_mask(width)) == '0);

   // Range and width checks. The range check takes precedence over the value check
   // on writes; a zero-width OP_READ is always good and touches nothing.
   always_comb begin
      chk_in      = '0;
      chk_in.off  = bp_ff[OFF_BITS-1:0];
      chk_in.blk  = bp_ff[OFF_BITS +: AW];
      chk_in.mw   = width;
      unique case (op_ff)
         OP_SET, OP_CLEAR, OP_TEST: begin
            if (past_size) begin
               chk_in.status = ST_RANGE;
            end else begin
               chk_in.do_read  = (op_ff == OP_TEST);
               chk_in.do_write = (op_ff != OP_TEST);
            end
         end
         OP_READ, OP_READ_REC: begin
            if (!is_rec && width == '0) begin
               chk_in.status = ST_OK;
            end else if (width == '0 || width > 7'd64) begin
               chk_in.status = ST_BAD;
            end else if (past_size) begin
               chk_in.status = ST_RANGE;
            end else begin
               chk_in.do_read = 1'b1;
               chk_in.mw      = mw_rd;
            end
         end
         OP_WRITE, OP_WRITE_REC: begin
            if (width > 7'd64 || (is_rec && width == '0)) begin
               chk_in.status = ST_BAD;
            end else if (end_bp > (BP_BITS+1)'(size)) begin
               chk_in.status = ST_RANGE;
            end else if (!value_fits) begin
               chk_in.status = ST_BAD;
            end else begin
               chk_in.do_write = (width != '0);
               chk_in.next     = is_rec ? (SIZE_BITS'(pos_ff) + 17'd1)
                                        : end_bp[SIZE_BITS-1:0];
            end
         end
         default: chk_in.status = ST_BAD;
      endcase
      chk_in.span = (7'(chk_in.off) + chk_in.mw) > 7'd64;
   end

   // Value to merge: a set writes a one-bit field of one, a clear one of zero.
   always_comb begin
      unique case (op_ff)
         OP_SET:   wval = 64'd1;
         OP_CLEAR: wval = '0;
         default:  wval = val_ff;
      endcase
   end

   // The field laid over a pair of words: low half is the first word, high half
   // the second.
   assign fmask = {64'b0, low_mask(chk_ff.mw)} << chk_ff.off;
   assign fdata = {64'b0, wval} << chk_ff.off;
   assign pair  = {mem_rd_data, w0_ff} >> chk_ff.off;

   // Memory port control. Writes to the two words fall in different states, S_RD0 and
   // S_RD1, and the next transaction reads only in its S_CHECK, after S_RESP and S_IDLE,
   // so no forwarding is needed.
   always_comb begin
      mem_ctl     = '0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      mem_rd_addr = chk_ff.blk;
      unique case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
         end
         S_CHECK: begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = chk_in.blk;
         end
         S_RD0: begin
            mem_ctl.rd_en = chk_ff.span;
            mem_rd_addr   = AW'(chk_ff.blk + 1'b1);
            mem_ctl.wr_en = chk_ff.do_write;
            mem_wr_addr   = chk_ff.blk;
            mem_wr_data   = (mem_rd_data & ~fmask[WORD_BITS-1:0])
                          | (fdata[WORD_BITS-1:0] & fmask[WORD_BITS-1:0]);
         end
         S_RD1: begin
            mem_ctl.wr_en = chk_ff.do_write && chk_ff.span;
            mem_wr_addr   = AW'(chk_ff.blk + 1'b1);
            mem_wr_data   = (mem_rd_data & ~fmask[2*WORD_BITS-1:WORD_BITS])
                          | (fdata[2*WORD_BITS-1:WORD_BITS]
                             & fmask[2*WORD_BITS-1:WORD_BITS]);
         end
         default: ;
      endcase
   end

   pbfs_store #(
      .WORDS     (STORE_WORDS),
      .ADDR_BITS (AW)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_addr_ff == LAST_WORD) state_in = S_IDLE;
         S_IDLE:  if (req_take) state_in = S_CHECK;
         S_CHECK: state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RESP;
         S_RESP:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= AW'(clr_addr_ff + 1'b1);
         end
      end
   end

   // Transaction payload and working registers; no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_operation;
         pos_ff <= req_position;
         fw_ff  <= req_field_width;
         val_ff <= req_write_value;
         bp_ff  <= (req_operation == OP_READ_REC || req_operation == OP_WRITE_REC)
                   ? rec_bp : BP_BITS'(req_position);
      end
      if (state_ff == S_CHECK) begin
         chk_ff <= chk_in;
      end
      if (state_ff == S_RD0) begin
         w0_ff <= mem_rd_data;
      end
      if (state_ff == S_RD1) begin
         res_value_ff <= chk_ff.do_read ? (pair[WORD_BITS-1:0] & low_mask(chk_ff.mw))
                                        : '0;
      end
   end

   // Output register: loaded from S_RESP whenever the previous response has gone.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_RESP && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && rsp_free) begin
         rsp_read_value_ff    <= res_value_ff;
         rsp_next_position_ff <= chk_ff.next;
         rsp_status_ff        <= chk_ff.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_read_value_ff;
   assign rsp_next_position = rsp_next_position_ff;
   assign rsp_status        = rsp_status_ff;

   // A flagged transaction must leave the store untouched.
   `PBFS_ASSERT_IMP(a_flag_no_write, clock, reset, (state_ff == S_RD0) && (chk_ff.status != ST_OK), !mem_ctl.wr_en)
   // The second word is only written by a good write that straddles two words.
   `PBFS_ASSERT_IMP(a_second_word_span, clock, reset, (state_ff == S_RD1) && mem_ctl.wr_en, chk_ff.span && chk_ff.do_write)
   // The response carries the checked status in the cycle after the hand-over.
   `PBFS_ASSERT_NEXT(a_resp_lands, clock, reset, (state_ff == S_RESP) && rsp_free, rsp_valid_ff && (rsp_status_ff == $past(chk_ff.status)))

endmodule

`default_nettype wire

>>> test/packed_bit_field_store_test.sv
// Self-checking testbench for packed_bit_field_store: directed and random requests are
// checked against a bit-accurate shadow of the word store and its two registers.
// Depends on pbfs_pkg for field widths and operation, status and register codes.
`timescale 1ns / 1ps

module packed_bit_field_store_test;
   import pbfs_pkg::*;

   localparam int unsigned STORE_WORDS = STORE_WORDS_DEFAULT;
   // Operation 7 has no meaning and must be refused with a bad-width status.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;
   // Idle cycles allowed before a register write once the last result is in.
   localparam int unsigned SETTLE_CYCLES = 10;
   // Length of the long receiver hold-off that backs the block up.
   localparam int unsigned HOLD_CYCLES = 400;

   typedef struct packed {
      logic [OP_BITS-1:0]   operation;
      logic [POS_BITS-1:0]  position;
      logic [FW_BITS-1:0]   field_width;
      logic [WORD_BITS-1:0] write_value;
   } store_request_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   read_value;
      logic [SIZE_BITS-1:0]   next_position;
      logic [STATUS_BITS-1:0] status;
   } store_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_BITS-1:0]       req_operation = '0;
   logic [POS_BITS-1:0]      req_position = '0;
   logic [FW_BITS-1:0]       req_field_width = '0;
   logic [WORD_BITS-1:0]     req_write_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [WORD_BITS-1:0]     rsp_read_value;
   logic [SIZE_BITS-1:0]     rsp_next_position;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // Shadow copy of the store and of its registers, updated in acceptance order.
   bit [WORD_BITS-1:0] mirror_words [0:STORE_WORDS-1];
   bit [SIZE_BITS-1:0] mirror_vector_bits = 17'h10000;
   bit [FW_BITS-1:0]   mirror_record_width = '0;

   store_request_type request_queue[$];     // requests still to be offered
   store_reply_type   predicted_replies[$]; // replies owed by the block, oldest first

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   bit          hold_phase = 1'b0;
   int unsigned hold_cycles = 0;
   bit          req_taken = 1'b0;
   int unsigned mismatch_count = 0;

   packed_bit_field_store #(
      .STORE_WORDS(STORE_WORDS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_field_width  (req_field_width),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_next_position(rsp_next_position),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Shadow store behaviour.
   // ---------------------------------------------------------------------------------

   function automatic bit [WORD_BITS-1:0] field_mask(input longint unsigned w);
      return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
   endfunction

   // Bits actually usable: the register value, capped by the size of the memory.
   function automatic longint unsigned usable_bits();
      longint unsigned cap;
      cap = longint'(STORE_WORDS) * WORD_BITS;
      return (mirror_vector_bits < cap) ? mirror_vector_bits : cap;
   endfunction

   function automatic bit [WORD_BITS-1:0] mirror_word(input longint unsigned idx);
      return (idx < STORE_WORDS) ? mirror_words[idx] : '0;
   endfunction

   // Reads w bits from bit bp upwards; bits past the end of the vector read as zero.
   function automatic bit [WORD_BITS-1:0] extract_field(input longint unsigned bp,
                                                        input longint unsigned w);
      longint unsigned size, blk, off;
      bit [WORD_BITS-1:0] v;
      size = usable_bits();
      blk  = bp >> 6;
      off  = bp & 63;
      if (bp + w > size) w = size - bp;
      v = mirror_word(blk) >> off;
      if (off != 0 && off + w > 64) v |= mirror_word(blk + 1) << (64 - off);
      return v & field_mask(w);
   endfunction

   // Writes w bits at bp, splitting the field over two words where it straddles.
   function automatic void insert_field(input longint unsigned bp, input longint unsigned w,
                                        input bit [WORD_BITS-1:0] value);
      longint unsigned blk, off, first;
      bit [WORD_BITS-1:0] m, m2;
      blk   = bp >> 6;
      off   = bp & 63;
      first = (off + w > 64) ? 64 - off : w;
      m     = field_mask(first) << off;
      if (blk < STORE_WORDS)
         mirror_words[blk] = (mirror_words[blk] & ~m) | ((value << off) & m);
      if (first < w) begin
         m2 = field_mask(w - first);
         if (blk + 1 < STORE_WORDS)
            mirror_words[blk + 1] = (mirror_words[blk + 1] & ~m2) | ((value >> first) & m2);
      end
   endfunction

   // Applies one request to the shadow store and returns the reply it must produce.
   function automatic store_reply_type apply_request(input store_request_type r);
      store_reply_type    y;
      longint unsigned    size, pos, w, bp, blk;
      bit [WORD_BITS-1:0] bitsel;
      y    = '0;
      size = usable_bits();
      pos  = r.position;
      case (r.operation)
         OP_SET, OP_CLEAR, OP_TEST: begin
            if (pos >= size) begin
               y.status = ST_RANGE;
            end else begin
               blk    = pos >> 6;
               bitsel = 64'd1 << (pos & 63);
               if (blk < STORE_WORDS) begin
                  if (r.operation == OP_SET) mirror_words[blk] |= bitsel;
                  else if (r.operation == OP_CLEAR) mirror_words[blk] &= ~bitsel;
                  else y.read_value = ((mirror_words[blk] & bitsel) != 0) ? 64'd1 : 64'd0;
               end
            end
         end
         OP_READ, OP_READ_REC: begin
            w  = (r.operation == OP_READ) ? longint'(r.field_width) : mirror_record_width;
            bp = (r.operation == OP_READ) ? pos : pos * mirror_record_width;
            // A zero-width field read is always fine and returns nothing.
            if (!(r.operation == OP_READ && w == 0)) begin
               if (w == 0 || w > 64) y.status = ST_BAD;
               else if (bp >= size) y.status = ST_RANGE;
               else y.read_value = extract_field(bp, w);
            end
         end
         OP_WRITE, OP_WRITE_REC: begin
            w  = (r.operation == OP_WRITE) ? longint'(r.field_width) : mirror_record_width;
            bp = (r.operation == OP_WRITE) ? pos : pos * mirror_record_width;
            // The range is judged before the value.
            if (w > 64 || (r.operation == OP_WRITE_REC && w == 0)) begin
               y.status = ST_BAD;
            end else if (bp + w > size) begin
               y.status = ST_RANGE;
            end else if ((r.write_value & ~field_mask(w)) != 0) begin
               y.status = ST_BAD;
            end else begin
               if (w != 0) insert_field(bp, w, r.write_value);
               y.next_position = (r.operation == OP_WRITE) ? SIZE_BITS'(bp + w)
                                                           : SIZE_BITS'(pos + 1);
            end
         end
         default: y.status = ST_BAD;
      endcase
      return y;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus generation.
   // ---------------------------------------------------------------------------------

   function automatic void queue_request(input logic [OP_BITS-1:0] op,
                                         input longint unsigned pos,
                                         input longint unsigned fw,
                                         input logic [WORD_BITS-1:0] value);
      store_request_type r;
      r.operation   = op;
      r.position    = POS_BITS'(pos);
      r.field_width = FW_BITS'(fw);
      r.write_value = value;
      request_queue.push_back(r);
   endfunction

   // Random request, biased towards the live part of the vector so that reads meet
   // earlier writes, and towards the end of the vector and word boundaries.
   function automatic store_request_type random_request();
      store_request_type  r;
      longint unsigned    size, last_index, hot_top, p, k, w;
      int unsigned        pick;
      bit [WORD_BITS-1:0] raw;
      size = usable_bits();
      pick = $urandom_range(0, 99);
      if (pick < 10)      r.operation = OP_SET;
      else if (pick < 18) r.operation = OP_CLEAR;
      else if (pick < 30) r.operation = OP_TEST;
      else if (pick < 50) r.operation = OP_READ;
      else if (pick < 72) r.operation = OP_WRITE;
      else if (pick < 84) r.operation = OP_READ_REC;
      else if (pick < 98) r.operation = OP_WRITE_REC;
      else                r.operation = OP_UNUSED;

      case ($urandom_range(0, 19))
         0:       r.field_width = '0;
         1, 2, 3: r.field_width = 7'd64;
         4:       r.field_width = FW_BITS'($urandom_range(65, 127));
         default: r.field_width = FW_BITS'($urandom_range(1, 63));
      endcase

      if (r.operation == OP_READ_REC || r.operation == OP_WRITE_REC) begin
         last_index = (mirror_record_width == 0) ? 40 : size / mirror_record_width;
         case ($urandom_range(0, 9))
            0, 1:    p = $urandom_range(0, 65535);
            2, 3, 4: begin
               k = $urandom_range(0, 3);
               p = (k > last_index + 1) ? 0 : last_index + 1 - k;
            end
            default: p = $urandom_range(0, (last_index < 40) ? last_index : 40);
         endcase
      end else begin
         hot_top = (size + 8 < 600) ? size + 8 : 600;
         case ($urandom_range(0, 19))
            0, 1, 2, 3:    p = $urandom_range(0, 65535);
            4, 5, 6, 7, 8: begin
               k = $urandom_range(0, 80);
               p = (k > size) ? 0 : size - k;
            end
            9, 10:   p = $urandom_range(0, 8) * 64 + $urandom_range(32, 63);
            default: p = $urandom_range(0, hot_top - 1);
         endcase
      end
      r.position = POS_BITS'((p > 65535) ? 65535 : p);

      w   = (r.operation == OP_WRITE_REC) ? longint'(mirror_record_width)
                                          : longint'(r.field_width);
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       r.write_value = raw;
         1:       r.write_value = field_mask(w);
         default: r.write_value = raw & field_mask(w);
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver. A new transaction is offered on the falling edge only once the
   // previous one has been taken; a stalled payload is left exactly as it was.
   // ---------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (request_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid       <= 1'b1;
            req_operation   <= request_queue[0].operation;
            req_position    <= request_queue[0].position;
            req_field_width <= request_queue[0].field_width;
            req_write_value <= request_queue[0].write_value;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken <= 1'b0;
   end

   // Acceptance: the shadow store is updated in the order the block takes requests,
   // and the reply it owes is queued for the monitor.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predicted_replies.push_back(apply_request({req_operation, req_position,
                                                    req_field_width, req_write_value}));
         void'(request_queue.pop_front());
         req_taken <= 1'b1;
      end
   end

   // Receiver stall. During a hold phase the result channel is first kept blocked for the
   // hold-off that HOLD_CYCLES sets, so that the block backs up and stalls its input.
   always @(negedge clock) begin
      if (hold_phase && hold_cycles < HOLD_CYCLES) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
         if (!hold_phase) hold_cycles <= 0;
      end
   end

   // Result monitor: every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      store_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_replies.size() == 0) begin
            $display("%0t ns: unexpected result: read_value %h next_position %0d status %0d",
                     $time, rsp_read_value, rsp_next_position, rsp_status);
            mismatch_count++;
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $display("%0t ns: read_value expected %h, actual %h",
                        $time, want.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_next_position !== want.next_position) begin
               $display("%0t ns: next_position expected %0d, actual %0d",
                        $time, want.next_position, rsp_next_position);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t ns: status expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencing of phases.
   // ---------------------------------------------------------------------------------

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] reg_index,
                                 input logic [CSR_DATA_BITS-1:0] reg_data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= reg_data;
      do @(posedge clock); while (!csr_ready);
      if (reg_index == CSR_VECTOR_BITS) mirror_vector_bits = reg_data;
      else if (reg_index == CSR_RECORD_WIDTH) mirror_record_width = reg_data[FW_BITS-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every request has been taken and every reply checked, then lets the
   // pipeline settle so that a following register write finds the block idle.
   task automatic wait_quiet();
      do @(posedge clock); while (request_queue.size() != 0 || predicted_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_BITS-1:0] vector_size,
                            input int unsigned rec_width, input int unsigned count,
                            input int unsigned send_pct, input int unsigned recv_pct);
      write_register(CSR_VECTOR_BITS, vector_size);
      write_register(CSR_RECORD_WIDTH, CSR_DATA_BITS'(rec_width));
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) request_queue.push_back(random_request());
      wait_quiet();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles lightly, receiver heavily.
      sender_idle_pct   = 21;
      receiver_idle_pct = 72;

      // Directed checks at the reset settings: full 65536-bit vector, no records.
      queue_request(OP_SET,   0,     0, '0);
      queue_request(OP_SET,   65535, 0, '0);
      queue_request(OP_TEST,  65535, 0, '0);
      queue_request(OP_CLEAR, 65535, 0, '0);
      queue_request(OP_TEST,  65535, 0, '0);
      queue_request(OP_TEST,  0,     0, '0);
      // A full-width field that straddles two words, written then read back.
      queue_request(OP_WRITE, 60, 64, 64'hDEAD_BEEF_CAFE_F00D);
      queue_request(OP_READ,  60, 64, '0);
      // Zero-width read anywhere, zero-width write right at the end.
      queue_request(OP_READ,  100,   0, '0);
      queue_request(OP_WRITE, 65535, 0, '0);
      queue_request(OP_WRITE, 65535, 1, 64'd1);
      // A read running off the end of the vector is cut short.
      queue_request(OP_READ,  65500, 64, '0);
      // Out of range and too wide at once: the range is reported.
      queue_request(OP_WRITE, 65534, 3, 64'hFF);
      queue_request(OP_WRITE, 10, 4,   64'd16);
      queue_request(OP_WRITE, 10, 127, 64'd1);
      queue_request(OP_READ,  10, 65,  '0);
      // Record requests are refused while the record width is zero.
      queue_request(OP_READ_REC,  0, 0, '0);
      queue_request(OP_WRITE_REC, 0, 0, '0);
      queue_request(OP_UNUSED,    5, 9, '1);
      queue_request(OP_WRITE, 0, 64, '1);
      wait_quiet();

      // Smallest vector with the widest records.
      write_register(CSR_VECTOR_BITS, 17'd1);
      write_register(CSR_RECORD_WIDTH, CSR_DATA_BITS'(64));
      queue_request(OP_SET,       0, 0,  '0);
      queue_request(OP_SET,       1, 0,  '0);
      queue_request(OP_READ_REC,  0, 0,  '0);
      queue_request(OP_WRITE_REC, 0, 0,  '0);
      queue_request(OP_READ,      0, 64, '0);
      queue_request(OP_WRITE,     1, 0,  '0);
      repeat (60) request_queue.push_back(random_request());
      wait_quiet();

      run_phase(17'h10000, 64, 350, 21, 72);

      // Now the sender idles heavily and the receiver lightly.
      run_phase(17'd1000,  7, 350, 72, 21);
      run_phase(17'd65535, 1, 300, 72, 21);

      // No idling from here on. The first of these phases opens with a long receiver
      // hold-off while the sender keeps offering requests.
      hold_phase = 1'b1;
      run_phase(17'd130, 13, 250, 0, 0);
      hold_phase = 1'b0;
      run_phase(17'h10000, 0, 150, 0, 0);
      run_phase(17'd4096, 33, 350, 0, 0);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legitimate run including the clearing pass.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
